[rtl/core/gfa_pkg.sv]
// Package for the grid frequency and AGC loop unit.
// Holds the sequencer states, the divider request and response and fixed constants.
// Depends on nothing.
`default_nettype none
package gfa_pkg;

	localparam int DivNumW = 55;
	localparam int DivDenW = 31;
	localparam int DivCntW = 6;

	localparam logic [22:0] NominalReset  = 23'd3276800;
	localparam logic [29:0] InertiaReset  = 30'd500000;
	localparam logic [15:0] StepReset     = 16'd66;
	localparam logic [29:0] InertiaZero   = 30'd500000;
	localparam logic [32:0] DampQ16       = 33'd5243;
	localparam int          DeadBand      = 328;
	localparam int          IntegralLimit = 3276800;
	localparam int          RateLimit     = 2147483647;
	localparam int          BandBelow     = 196608;
	localparam int          BandAbove     = 131072;
	localparam int          FreqMax       = 8388607;
	localparam logic [34:0] CorrClip      = 35'd3355443749;
	localparam logic [32:0] CorrRecip     = 33'd2814749767;
	localparam logic [32:0] LimitRecip    = 33'd1099511628;

	localparam logic [1:0] RegNominal  = 2'd0;
	localparam logic [1:0] RegInertia  = 2'd1;
	localparam logic [1:0] RegStep     = 2'd2;
	localparam logic [1:0] RegCapacity = 2'd3;

	typedef enum logic [3:0] {
		ST_IDLE, ST_M1, ST_D1, ST_M2, ST_W1, ST_M3, ST_F, ST_E,
		ST_M4, ST_I, ST_M5, ST_R1, ST_R2, ST_R3, ST_OUT
	} state_t;

	typedef struct packed {
		logic               start;
		logic [DivNumW-1:0] num;
		logic [DivDenW-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic               done;
		logic [DivNumW-1:0] quo;
	} div_rsp_t;

endpackage
`default_nettype wire

[rtl/core/gfa_in_if.sv]
// Input channel of the grid frequency loop: one beat per simulation tick.
// Depends on nothing.
`default_nettype none
interface gfa_in_if;
	logic        valid;
	logic        ready;
	logic [29:0] generation_kw;
	logic [29:0] load_kw;
	logic [29:0] losses_kw;
	modport source (output valid, generation_kw, load_kw, losses_kw, input ready);
	modport sink (input valid, generation_kw, load_kw, losses_kw, output ready);
endinterface
`default_nettype wire

[rtl/core/gfa_out_if.sv]
// Output channel of the grid frequency loop: one result beat per tick.
// Depends on nothing.
`default_nettype none
interface gfa_out_if;
	logic               valid;
	logic               ready;
	logic        [22:0] frequency;
	logic signed [21:0] correction_kw;
	logic               correction_valid;
	modport source (output valid, frequency, correction_kw, correction_valid, input ready);
	modport sink (input valid, frequency, correction_kw, correction_valid, output ready);
endinterface
`default_nettype wire

[rtl/core/gfa_div.sv]
// Restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on gfa_pkg.
`default_nettype none
module gfa_div
	import gfa_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_req_t req,
	output div_rsp_t      rsp
);
	logic [DivNumW-1:0] num_q;
	logic [DivDenW-1:0] den_q;
	logic [DivDenW-1:0] rem_q;
	logic [DivCntW-1:0] cnt_q;
	logic               done_q;
	logic [DivDenW:0]   trial;
	logic               qbit;

	always_comb begin
		trial = {rem_q, num_q[DivNumW-1]};
		qbit = (trial >= {1'b0, den_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			done_q <= 1'b0;
		end else if (req.start) begin
			cnt_q <= DivCntW'(DivNumW);
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == DivCntW'(1));
			if (cnt_q != '0) cnt_q <= cnt_q - DivCntW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			rem_q <= qbit ? DivDenW'(trial - {1'b0, den_q}) : trial[DivDenW-1:0];
			num_q <= {num_q[DivNumW-2:0], qbit};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo = num_q;
endmodule
`default_nettype wire

[rtl/core/grid_frequency_agc_loop_unit.sv]
// Top level of the grid frequency loop with PI automatic generation control.
// Depends on gfa_pkg, gfa_in_if, gfa_out_if and gfa_div.
`default_nettype none
// One tick is taken per input beat and gives one result beat. A sequencer drives one
// shared 33 by 33 bit signed multiplier and one divider that yields a bit a cycle;
// the divider serves only the inertia division, and the fixed divisions of the
// controller use reciprocal multiplication. A tick in the dead band, or with zero
// capacity, skips the control states and goes straight to the output state. The
// input is not ready from the accepted beat until its result is taken.
module grid_frequency_agc_loop_unit
	import gfa_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  cfg_we,
	input  wire logic  [1:0] cfg_index,
	input  wire logic  [29:0] cfg_data,
	gfa_in_if.sink     in_ch,
	gfa_out_if.source  out_ch
);
	state_t state_q, state_d;

	logic        [22:0] nom_q;
	logic        [29:0] ke_q;
	logic        [15:0] dt_q;
	logic        [29:0] cap_q;
	logic        [22:0] f_q;
	logic signed [22:0] integ_q;

	logic signed [32:0] ma_q, mb_q;
	logic signed [65:0] p_q;
	logic signed [23:0] damp_q;
	logic               neg_q;
	logic        [20:0] limit_q;
	logic signed [21:0] corr_q;
	logic               cval_q;

	div_req_t dreq;
	div_rsp_t drsp;

	logic        [65:0] abs_p;
	logic signed [56:0] qs;
	logic signed [56:0] rate_raw;
	logic signed [31:0] rate_new;
	logic signed [33:0] fsum;
	logic signed [33:0] lo, hi;
	logic        [22:0] f_new;
	logic signed [23:0] e;
	logic               active;
	logic signed [24:0] isum;
	logic signed [22:0] integ_new;
	logic signed [27:0] svar;
	logic        [29:0] ke_eff;
	logic        [34:0] cx;
	logic        [31:0] cx_inc;
	logic        [20:0] cmag;
	logic        [20:0] cmag_lim;

	gfa_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	always_comb begin
		abs_p = p_q[65] ? 66'(-p_q) : 66'(p_q);
		qs = neg_q ? -$signed({2'b00, drsp.quo}) : $signed({2'b00, drsp.quo});
		rate_raw = qs - 57'(damp_q);
		if (rate_raw > 57'sd2147483647) rate_new = 32'(RateLimit);
		else if (rate_raw < -57'sd2147483647) rate_new = -32'(RateLimit);
		else rate_new = rate_raw[31:0];

		fsum = $signed({11'b0, f_q}) + 34'($signed(p_q[48:16]));
		lo = $signed({11'b0, nom_q}) - 34'(BandBelow);
		if (lo < 0) lo = '0;
		hi = $signed({11'b0, nom_q}) + 34'(BandAbove);
		if (hi > 34'(FreqMax)) hi = 34'(FreqMax);
		if (fsum < lo) f_new = lo[22:0];
		else if (fsum > hi) f_new = hi[22:0];
		else f_new = fsum[22:0];

		e = $signed({1'b0, nom_q}) - $signed({1'b0, f_q});
		active = (e >= 24'(DeadBand) || e <= -24'(DeadBand)) && (cap_q != '0);

		isum = 25'(integ_q) + 25'($signed(p_q[39:16]));
		if (isum > 25'(IntegralLimit)) integ_new = 23'(IntegralLimit);
		else if (isum < -25'(IntegralLimit)) integ_new = -23'(IntegralLimit);
		else integ_new = isum[22:0];
		svar = 28'(e) * 28'sd5 + 28'(integ_new);

		ke_eff = (ke_q == '0) ? InertiaZero : ke_q;
		cx = (abs_p[55:21] > CorrClip) ? CorrClip : abs_p[55:21];
		cx_inc = cx[31:0] + 32'd1;
		cmag = p_q[63:43];
		cmag_lim = (cmag > limit_q) ? limit_q : cmag;

		dreq.start = 1'b0;
		dreq.num = '0;
		dreq.den = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_ch.valid) state_d = ST_M1;
			ST_M1: state_d = ST_D1;
			ST_D1: begin
				dreq.start = 1'b1;
				dreq.num = abs_p[DivNumW-1:0];
				dreq.den = {ke_eff, 1'b0};
				state_d = ST_M2;
			end
			ST_M2: state_d = ST_W1;
			ST_W1: if (drsp.done) state_d = ST_M3;
			ST_M3: state_d = ST_F;
			ST_F: state_d = ST_E;
			ST_E: state_d = active ? ST_M4 : ST_OUT;
			ST_M4: state_d = ST_I;
			ST_I: state_d = ST_M5;
			ST_M5: state_d = ST_R1;
			ST_R1: state_d = ST_R2;
			ST_R2: state_d = ST_R3;
			ST_R3: state_d = ST_OUT;
			ST_OUT: if (out_ch.ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nom_q <= NominalReset;
			ke_q <= InertiaReset;
			dt_q <= StepReset;
			cap_q <= '0;
			f_q <= NominalReset;
			integ_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					RegNominal:  nom_q <= cfg_data[22:0];
					RegInertia:  ke_q <= cfg_data;
					RegStep:     dt_q <= cfg_data[15:0];
					RegCapacity: cap_q <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == ST_F) f_q <= f_new;
			if (state_q == ST_I) integ_q <= integ_new;
		end
	end

	always_ff @(posedge clk) begin
		p_q <= ma_q * mb_q;
		unique case (state_q)
			ST_IDLE: begin
				ma_q <= 33'($signed({2'b0, in_ch.generation_kw})
					- $signed({2'b0, in_ch.load_kw}) - $signed({2'b0, in_ch.losses_kw}));
				mb_q <= $signed({10'b0, nom_q});
			end
			ST_M1: begin
				ma_q <= $signed({10'b0, f_q}) - $signed({10'b0, nom_q});
				mb_q <= DampQ16;
			end
			ST_D1: neg_q <= p_q[65];
			ST_M2: damp_q <= p_q[39:16];
			ST_W1: if (drsp.done) begin
				ma_q <= 33'(rate_new);
				mb_q <= $signed({17'b0, dt_q});
			end
			ST_E: begin
				ma_q <= 33'(e);
				mb_q <= $signed({17'b0, dt_q});
				corr_q <= '0;
				cval_q <= 1'b0;
			end
			ST_M4: begin
				ma_q <= $signed({3'b0, cap_q});
				mb_q <= LimitRecip;
			end
			ST_I: begin
				ma_q <= $signed({3'b0, cap_q});
				mb_q <= 33'(svar);
			end
			ST_M5: limit_q <= p_q[60:40];
			ST_R1: begin
				neg_q <= p_q[65];
				ma_q <= $signed({1'b0, cx_inc});
				mb_q <= CorrRecip;
			end
			ST_R3: begin
				corr_q <= neg_q ? -$signed({1'b0, cmag_lim}) : $signed({1'b0, cmag_lim});
				cval_q <= 1'b1;
			end
			default: ;
		endcase
	end

	assign in_ch.ready = (state_q == ST_IDLE);
	assign out_ch.valid = (state_q == ST_OUT);
	assign out_ch.frequency = f_q;
	assign out_ch.correction_kw = corr_q;
	assign out_ch.correction_valid = cval_q;
endmodule
`default_nettype wire

[rtl/core/gfa_check.sv]
// Port-level checker for the grid frequency loop unit, bound to the top level.
// Depends on grid_frequency_agc_loop_unit.
`default_nettype none
module gfa_check (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [22:0] frequency,
	input wire logic [21:0] correction_kw,
	input wire logic        correction_valid
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(frequency)
		&& $stable(correction_kw) && $stable(correction_valid))
		else $error("result beat changed while stalled");
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input ready while a result waits");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input ready straight after a beat");
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !correction_valid |-> correction_kw == 22'd0)
		else $error("correction without control action");
endmodule

bind grid_frequency_agc_loop_unit gfa_check u_gfa_check (
	.clk(clk), .arst_n(arst_n),
	.in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.frequency(out_ch.frequency), .correction_kw(out_ch.correction_kw),
	.correction_valid(out_ch.correction_valid)
);
`default_nettype wire

[test/tb_top.sv]
// Testbench for grid_frequency_agc_loop_unit: directed and random ticks over several settings.
// Depends on gfa_pkg, gfa_in_if, gfa_out_if and the unit itself.
// It predicts the swing equation and the PI control, then checks each result beat.
`timescale 1ns / 1ps
module tb_top;
	import gfa_pkg::*;

	localparam int WatchdogLimit = 40000;
	localparam logic [29:0] W30Max = 30'h3FFFFFFF;

	typedef struct packed {
		logic [29:0] generation_kw;
		logic [29:0] load_kw;
		logic [29:0] losses_kw;
	} tick_in_t;

	typedef struct packed {
		logic [22:0] frequency;
		logic [21:0] correction_kw;
		logic        correction_valid;
	} tick_out_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [29:0] cfg_data;

	gfa_in_if  in_ch ();
	gfa_out_if out_ch ();

	grid_frequency_agc_loop_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_we  (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch   (in_ch.sink),
		.out_ch  (out_ch.source)
	);

	tick_in_t  tick_q[$];
	tick_out_t grid_result_q[$];
	int        fail_count;
	int        idle_cycles;
	int        send_gap_pct;
	int        recv_stall_pct;

	logic [22:0] nominal_reg;
	logic [29:0] inertia_reg;
	logic [15:0] step_reg;
	logic [29:0] capacity_reg;
	longint      grid_freq;
	longint      agc_integral;

	initial begin
		clk = 1'b0;
	end
	always #6 clk = ~clk;

	function automatic longint clip(input longint v, input longint lo, input longint hi);
		if (v < lo) begin
			return lo;
		end
		if (v > hi) begin
			return hi;
		end
		return v;
	endfunction

	function automatic void predict_tick(input tick_in_t t);
		longint imb, nom, ke, dt, f, rate, lo, hi, e, integ, cap, corr, lim;
		tick_out_t r;
		nom = longint'(nominal_reg);
		ke = (inertia_reg == 30'd0) ? longint'(InertiaZero) : longint'(inertia_reg);
		dt = longint'(step_reg);
		f = grid_freq;
		imb = longint'(t.generation_kw) - longint'(t.load_kw) - longint'(t.losses_kw);
		rate = (imb * nom) / (2 * ke) - (((f - nom) * longint'(DampQ16)) >>> 16);
		rate = clip(rate, -longint'(RateLimit), longint'(RateLimit));
		f = f + ((rate * dt) >>> 16);
		lo = clip(nom - BandBelow, 0, FreqMax);
		hi = clip(nom + BandAbove, 0, FreqMax);
		f = clip(f, lo, hi);
		grid_freq = f;
		corr = 0;
		r.correction_valid = 1'b0;
		e = nom - f;
		cap = longint'(capacity_reg);
		if ((e >= DeadBand || e <= -DeadBand) && cap != 0) begin
			integ = clip(agc_integral + ((e * dt) >>> 16), -IntegralLimit, IntegralLimit);
			agc_integral = integ;
			corr = (cap * (5 * e + integ)) / 64'sd6553600000;
			lim = cap / 1000;
			corr = clip(corr, -lim, lim);
			r.correction_valid = 1'b1;
		end
		r.frequency = f[22:0];
		r.correction_kw = corr[21:0];
		grid_result_q.push_back(r);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.generation_kw <= '0;
			in_ch.load_kw <= '0;
			in_ch.losses_kw <= '0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				predict_tick({in_ch.generation_kw, in_ch.load_kw, in_ch.losses_kw});
			end
			if (!in_ch.valid || in_ch.ready) begin
				if (tick_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
					tick_in_t t;
					t = tick_q.pop_front();
					in_ch.valid <= 1'b1;
					in_ch.generation_kw <= t.generation_kw;
					in_ch.load_kw <= t.load_kw;
					in_ch.losses_kw <= t.losses_kw;
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			idle_cycles <= 0;
		end else begin
			out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
			if (idle_cycles >= WatchdogLimit) begin
				$display("tb_top: FAIL");
				$finish;
			end
			if (out_ch.valid && out_ch.ready) begin
				if (grid_result_q.size() == 0) begin
					$error("result beat with no expectation waiting");
					fail_count++;
				end else begin
					tick_out_t x;
					x = grid_result_q.pop_front();
					if (out_ch.frequency !== x.frequency) begin
						$error("frequency: expected %0d, got %0d", x.frequency, out_ch.frequency);
						fail_count++;
					end
					if (out_ch.correction_kw !== x.correction_kw) begin
						$error("correction_kw: expected %0d, got %0d",
							$signed(x.correction_kw), out_ch.correction_kw);
						fail_count++;
					end
					if (out_ch.correction_valid !== x.correction_valid) begin
						$error("correction_valid: expected %0d, got %0d",
							x.correction_valid, out_ch.correction_valid);
						fail_count++;
					end
				end
			end
		end
	end

	task automatic wait_idle();
		while (tick_q.size() != 0 || grid_result_q.size() != 0 || in_ch.valid) begin
			@(posedge clk);
		end
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [29:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			RegNominal: nominal_reg = val[22:0];
			RegInertia: inertia_reg = val;
			RegStep: step_reg = val[15:0];
			RegCapacity: capacity_reg = val;
			default: ;
		endcase
	endtask

	task automatic set_regs(input logic [29:0] nom, input logic [29:0] ke,
			input logic [29:0] dt, input logic [29:0] cap);
		wait_idle();
		write_reg(RegNominal, nom);
		write_reg(RegInertia, ke);
		write_reg(RegStep, dt);
		write_reg(RegCapacity, cap);
	endtask

	task automatic add_tick(input logic [29:0] g, input logic [29:0] l, input logic [29:0] s);
		tick_q.push_back({g, l, s});
	endtask

	// Mostly near-balanced ticks so the frequency stays inside the band and the
	// controller integrates; the rest are raw or extreme values.
	task automatic add_random(input int count);
		int kind;
		logic [29:0] g, l, s;
		longint d;
		for (int i = 0; i < count; i++) begin
			kind = $urandom_range(99);
			g = 30'($urandom());
			l = 30'($urandom());
			s = 30'($urandom());
			if (kind < 70) begin
				s = 30'($urandom_range(2000));
				d = longint'($urandom_range(4000)) - 2000;
				d = longint'(g) - longint'(s) + d;
				l = (d < 0) ? 30'd0 : (d > W30Max) ? W30Max : d[29:0];
			end else if (kind < 85) begin
				g = ($urandom_range(1) != 0) ? W30Max : 30'd0;
				l = ($urandom_range(1) != 0) ? W30Max : 30'd0;
				s = ($urandom_range(1) != 0) ? W30Max : 30'd0;
			end
			add_tick(g, l, s);
		end
	endtask

	initial begin
		fail_count = 0;
		send_gap_pct = 0;
		recv_stall_pct = 0;
		in_ch.valid = 1'b0;
		in_ch.generation_kw = '0;
		in_ch.load_kw = '0;
		in_ch.losses_kw = '0;
		out_ch.ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = RegNominal;
		cfg_data = '0;
		nominal_reg = NominalReset;
		inertia_reg = InertiaReset;
		step_reg = StepReset;
		capacity_reg = '0;
		grid_freq = longint'(NominalReset);
		agc_integral = 0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: zero capacity, so no control acts.
		add_tick(0, 0, 0);
		add_tick(W30Max, 0, 0);
		add_tick(0, W30Max, 0);
		add_tick(0, 0, W30Max);
		add_tick(W30Max, W30Max, W30Max);
		add_tick(1000, 1000, 0);
		set_regs(30'd3276800, 30'd0, 30'd6554, 30'd1000000);
		add_tick(0, 1000, 0);
		add_tick(1000, 0, 0);
		add_tick(500, 500, 0);
		add_tick(W30Max, 0, 0);
		add_tick(0, W30Max, W30Max);
		add_tick(0, 0, 0);
		set_regs(30'h3FFFFFFF, 30'h3FFFFFFF, 30'hFFFF, 30'h3FFFFFFF);
		add_tick(0, W30Max, 0);
		add_tick(W30Max, 0, 0);
		add_tick(7, 3, 1);
		set_regs(30'd0, 30'd1, 30'd0, 30'd1);
		add_tick(W30Max, 0, 0);
		add_tick(0, W30Max, 0);
		add_tick(0, 0, 0);

		set_regs(30'd3276800, 30'd0, 30'd66, 30'd1000000);
		add_random(300);
		wait_idle();
		send_gap_pct = 54;
		set_regs(30'd3932160, 30'd1000, 30'd6554, 30'h3FFFFFFF);
		add_random(300);
		wait_idle();
		send_gap_pct = 0;
		recv_stall_pct = 54;
		set_regs(30'd0, 30'd20000, 30'd65535, 30'd12345);
		add_random(250);
		wait_idle();
		send_gap_pct = 30;
		recv_stall_pct = 30;
		set_regs(30'h3FFFFFFF, 30'h3FFFFFFF, 30'd0, 30'd1);
		add_random(200);
		wait_idle();
		set_regs(30'd3276800, 30'd20000, 30'd655, 30'd500000);
		add_random(250);
		wait_idle();
		send_gap_pct = 0;
		recv_stall_pct = 0;
		set_regs(30'd6553600, 30'd0, 30'd3000, 30'd80000);
		add_random(280);
		wait_idle();
		repeat (300) @(posedge clk);
		if (fail_count == 0 && grid_result_q.size() == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end

endmodule
